>>> sv/b64lw_pkg.sv
// b64lw_pkg: types, character codes and the symbol table of the base64 line-wrap encoder.
// No dependencies. Imported by every module of the block.
`timescale 1ns / 1ps
package b64lw_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0] LINE_LENGTH_RESET = 8'd64;
   localparam logic [7:0] CHAR_PAD          = 8'h3D;
   localparam logic [7:0] CHAR_NEWLINE      = 8'h0A;
   localparam logic [7:0] CHAR_UPPER_A      = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A      = 8'h61;
   localparam logic [7:0] CHAR_DIGIT_0      = 8'h30;
   localparam logic [7:0] CHAR_PLUS         = 8'h2B;
   localparam logic [7:0] CHAR_SLASH        = 8'h2F;

   // register indexes
   localparam logic REG_LINE_LENGTH = 1'b0;

   // back-end step indexes: 0..3 are chunk characters
   localparam logic [2:0] STEP_FIRST   = 3'd0;
   localparam logic [2:0] STEP_LAST_SYM = 3'd3;
   localparam logic [2:0] STEP_NEWLINE = 3'd4;

   // one unit of work for the back end
   typedef struct packed {
      logic            has_chunk;  // four characters of a group come first
      logic [1:0]      count;      // bytes in the group, 1..3
      logic            newline;    // a newline follows
      logic            end_nl;     // that newline ends the message
      logic [3:0][5:0] sym;
   } job_type;

   function automatic logic [7:0] b64_char(input logic [5:0] s);
      logic [7:0] c;
      c = CHAR_SLASH;
      if (s < 6'd26) begin
         c = CHAR_UPPER_A + {2'b00, s};
      end else if (s < 6'd52) begin
         c = CHAR_LOWER_A + {2'b00, s - 6'd26};
      end else if (s < 6'd62) begin
         c = CHAR_DIGIT_0 + {2'b00, s - 6'd52};
      end else if (s == 6'd62) begin
         c = CHAR_PLUS;
      end
      return c;
   endfunction

endpackage

>>> sv/b64lw_front.sv
// b64lw_front: accepts message bytes, gathers groups of three, tracks the line position
// and queues one job per group or message end. Depends on b64lw_pkg.
`timescale 1ns / 1ps
module b64lw_front import b64lw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       req_empty_message,
   input  logic [7:0] line_length,
   output logic       push,
   output job_type    push_job,
   input  logic       queue_full
);

   logic [1:0][7:0] pending_ff, pending_in;
   logic [1:0]      fill_ff, fill_in;
   logic [7:0]      line_pos_ff, line_pos_in;

   logic       accept;
   logic [1:0] fill_eff;
   logic       full_group;
   logic [7:0] b0, b1, b2;
   logic [8:0] pos_next;
   logic [8:0] threshold;
   logic       wrap_on;
   logic       wrap_hit;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      fill_eff   = (fill_ff == 2'd3) ? 2'd2 : fill_ff;
      full_group = (fill_eff == 2'd2);

      b0 = (fill_eff == 2'd0) ? req_data_byte : pending_ff[0];
      b1 = 8'd0;
      if (fill_eff == 2'd1) begin
         b1 = req_data_byte;
      end else if (fill_eff == 2'd2) begin
         b1 = pending_ff[1];
      end
      b2 = full_group ? req_data_byte : 8'd0;

      pos_next  = {1'b0, line_pos_ff} + 9'd4;
      threshold = ({1'b0, line_length} + 9'd3) & 9'h1FC;
      wrap_on   = (line_length != 8'd0);
      wrap_hit  = full_group && wrap_on && (pos_next >= threshold) && !req_last_byte;

      push_job.has_chunk = !req_empty_message && (full_group || req_last_byte);
      push_job.count     = full_group ? 2'd3 : fill_eff + 2'd1;
      push_job.newline   = req_empty_message || req_last_byte || wrap_hit;
      push_job.end_nl    = req_empty_message || req_last_byte;
      push_job.sym[0]    = b0[7:2];
      push_job.sym[1]    = {b0[1:0], b1[7:4]};
      push_job.sym[2]    = {b1[3:0], b2[7:6]};
      push_job.sym[3]    = b2[5:0];

      push = accept && (req_empty_message || req_last_byte || full_group);

      pending_in  = pending_ff;
      fill_in     = fill_ff;
      line_pos_in = line_pos_ff;
      if (accept) begin
         if (req_empty_message || req_last_byte) begin
            pending_in  = '0;
            fill_in     = 2'd0;
            line_pos_in = 8'd0;
         end else if (full_group) begin
            pending_in = '0;
            fill_in    = 2'd0;
            if (wrap_on) begin
               if (wrap_hit) begin
                  line_pos_in = 8'd0;
               end else if (pos_next[8]) begin
                  line_pos_in = 8'hFF;
               end else begin
                  line_pos_in = pos_next[7:0];
               end
            end
         end else begin
            pending_in[fill_eff[0]] = req_data_byte;
            fill_in                 = fill_eff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         fill_ff     <= 2'd0;
         line_pos_ff <= 8'd0;
      end else begin
         pending_ff  <= pending_in;
         fill_ff     <= fill_in;
         line_pos_ff <= line_pos_in;
      end
   end

endmodule

>>> sv/b64lw_queue.sv
// b64lw_queue: small job queue between front and back end.
// Depends on b64lw_pkg for the job type.
`timescale 1ns / 1ps
module b64lw_queue import b64lw_pkg::*; #(
   parameter int unsigned Depth = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] PtrMax = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] CntMax = CntWidth'(Depth);

   job_type entry_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == CntMax);
   assign empty   = (count_ff == '0);
   assign pop_job = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrMax) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrMax) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/b64lw_back.sv
// b64lw_back: steps through one job at a time, one character per cycle while the output
// is not stalled, into the output register. Depends on b64lw_pkg.
`timescale 1ns / 1ps
module b64lw_back import b64lw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  job_type    pop_job,
   input  logic       queue_empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char
);

   job_type    job_ff, job_in;
   logic       busy_ff, busy_in;
   logic [2:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_last_ff, out_last_in;

   logic       advance;
   logic       final_step;
   logic [7:0] cur_char;
   logic       cur_last;

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_char  = out_char_ff;
   assign rsp_last_char = out_last_ff;

   always_comb begin
      advance    = busy_ff && (!out_valid_ff || !rsp_stall);
      final_step = (step_ff == STEP_NEWLINE) ||
                   ((step_ff == STEP_LAST_SYM) && !job_ff.newline);

      cur_last = 1'b0;
      case (step_ff)
         3'd0:    cur_char = b64_char(job_ff.sym[0]);
         3'd1:    cur_char = b64_char(job_ff.sym[1]);
         3'd2:    cur_char = (job_ff.count == 2'd1) ? CHAR_PAD : b64_char(job_ff.sym[2]);
         3'd3:    cur_char = (job_ff.count == 2'd3) ? b64_char(job_ff.sym[3]) : CHAR_PAD;
         default: begin
            cur_char = CHAR_NEWLINE;
            cur_last = job_ff.end_nl;
         end
      endcase

      // take the next job when idle or as the current one finishes
      pop = !queue_empty && (!busy_ff || (advance && final_step));

      job_in  = job_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      if (pop) begin
         job_in  = pop_job;
         busy_in = 1'b1;
         step_in = pop_job.has_chunk ? STEP_FIRST : STEP_NEWLINE;
      end else if (advance) begin
         if (final_step) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end

      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_char_in  = cur_char;
         out_last_in  = cur_last;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> sv/base64_encoder_line_wrap.sv
// Base64 encoder with line wrapping: one message byte per word in, one character per word out.
// Input takes a byte every cycle while the job queue has room; the back end emits one character
// per cycle unless stalled, four per group of three bytes, five when a wrap newline follows.
// A message end emits its last chunk, if any, plus the closing newline.
// A job goes through its queue entry and the back-end job register to the output register.
// Synchronous active-high reset clears the queue, the group state and sets line_length to 64.
// Depends on b64lw_pkg, b64lw_front, b64lw_queue and b64lw_back.
`timescale 1ns / 1ps
module base64_encoder_line_wrap import b64lw_pkg::*; #(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        req_empty_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_char,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0] line_length_ff, line_length_in;
   logic       csr_write;
   logic       push, pop, queue_full, queue_empty;
   job_type    push_job, pop_job;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_LINE_LENGTH) ? {24'd0, line_length_ff} : 32'd0;

   always_comb begin
      line_length_in = line_length_ff;
      if (csr_write && (csr_paddr[2] == REG_LINE_LENGTH)) begin
         line_length_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_LENGTH_RESET;
      end else begin
         line_length_ff <= line_length_in;
      end
   end

   b64lw_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .req_empty_message (req_empty_message),
      .line_length       (line_length_ff),
      .push              (push),
      .push_job          (push_job),
      .queue_full        (queue_full)
   );

   b64lw_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   b64lw_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_job       (pop_job),
      .queue_empty   (queue_empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking bench for base64_encoder_line_wrap, with its own encoder prediction.
// Depends on b64lw_pkg (character codes, register index) and the RTL of the block.
`timescale 1ns / 1ps
module tb_top;
   import b64lw_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       fin;
      logic       empty;
   } msg_word_type;

   typedef struct {
      logic [7:0] ch;
      logic       fin;
   } char_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        req_empty_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_last_char;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   base64_encoder_line_wrap DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte), .req_empty_message(req_empty_message),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_char(rsp_out_char),
      .rsp_last_char(rsp_last_char),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   msg_word_type  byte_queue[$];
   char_word_type char_queue[$];
   int unsigned words_queued = 0;
   int unsigned words_taken = 0;
   int unsigned chars_seen = 0;
   int unsigned errors = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   bit          gaps_on = 1'b1;
   bit          stalls_on = 1'b1;

   // encoder state mirrored by the bench
   string       symbol_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   logic [7:0]  wrap_length = LINE_LENGTH_RESET;
   logic [7:0]  held_bytes[2] = '{8'd0, 8'd0};
   logic [1:0]  held_count = 2'd0;
   logic [7:0]  column = 8'd0;

   task automatic report(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   function automatic void expect_char(input logic [7:0] c, input logic fin);
      char_queue.push_back('{c, fin});
   endfunction

   function automatic void clear_message();
      held_bytes = '{8'd0, 8'd0};
      held_count = 2'd0;
      column = 8'd0;
   endfunction

   function automatic void expect_group(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input int unsigned n);
      logic [5:0] s[4];
      s[0] = b0[7:2];
      s[1] = {b0[1:0], b1[7:4]};
      s[2] = {b1[3:0], b2[7:6]};
      s[3] = b2[5:0];
      expect_char(symbol_set[s[0]], 1'b0);
      expect_char(symbol_set[s[1]], 1'b0);
      expect_char((n == 1) ? CHAR_PAD : symbol_set[s[2]], 1'b0);
      expect_char((n == 3) ? symbol_set[s[3]] : CHAR_PAD, 1'b0);
   endfunction

   function automatic void encode_byte(input logic [7:0] data, input logic fin,
                                       input logic empty);
      int unsigned pos;
      int unsigned limit;
      if (empty) begin
         expect_char(CHAR_NEWLINE, 1'b1);
         clear_message();
      end else if (held_count >= 2'd2) begin
         expect_group(held_bytes[0], held_bytes[1], data, 3);
         held_count = 2'd0;
         held_bytes = '{8'd0, 8'd0};
         if (wrap_length != 8'd0) begin
            pos = column + 4;
            limit = (wrap_length + 3) & 32'h1fc;
            if (pos >= limit && !fin) begin
               expect_char(CHAR_NEWLINE, 1'b0);
               pos = 0;
            end
            column = (pos > 255) ? 8'd255 : pos[7:0];
         end
         if (fin) begin
            expect_char(CHAR_NEWLINE, 1'b1);
            clear_message();
         end
      end else if (fin) begin
         if (held_count == 2'd0) expect_group(data, 8'd0, 8'd0, 1);
         else expect_group(held_bytes[0], data, 8'd0, 2);
         expect_char(CHAR_NEWLINE, 1'b1);
         clear_message();
      end else begin
         held_bytes[held_count[0]] = data;
         held_count = held_count + 2'd1;
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sender: presents the next word once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_byte(req_data_byte, req_last_byte, req_empty_message);
            words_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               req_data_byte <= byte_queue[0].data;
               req_last_byte <= byte_queue[0].fin;
               req_empty_message <= byte_queue[0].empty;
               void'(byte_queue.pop_front());
               req_valid <= 1'b1;
               gap_left = gaps_on ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each taken character, stalls at random
   always @(posedge clock) begin
      char_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (char_queue.size() == 0) begin
               report($sformatf("char %0d: 0x%02h with nothing expected", chars_seen,
                                rsp_out_char));
            end else begin
               want = char_queue.pop_front();
               if (rsp_out_char !== want.ch)
                  report($sformatf("char %0d: out_char 0x%02h, expected 0x%02h", chars_seen,
                                   rsp_out_char, want.ch));
               if (rsp_last_char !== want.fin)
                  report($sformatf("char %0d: last_char %b, expected %b", chars_seen,
                                   rsp_last_char, want.fin));
            end
            chars_seen++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_word(input logic [7:0] data, input logic fin, input logic empty);
      byte_queue.push_back('{data, fin, empty});
      words_queued++;
   endtask

   // random messages; the last one may stay open into the next setting
   task automatic queue_messages(input int unsigned budget, input int unsigned first_len);
      int unsigned n;
      int unsigned left;
      n = 0;
      left = first_len;
      while (n < budget) begin
         if (left == 0) begin
            if ($urandom_range(0, 9) == 0) begin
               push_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
               n++;
            end else begin
               left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(1, 12);
            end
         end else if ($urandom_range(0, 29) == 0) begin
            // abort with pending bytes
            push_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            left = 0;
            n++;
         end else begin
            left--;
            push_word(8'($urandom_range(0, 255)), left == 0, 1'b0);
            n++;
         end
      end
   endtask

   task automatic set_line_length(input logic [7:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_LINE_LENGTH, 2'b00};
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      wrap_length = value;
      // read back
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== value)
         report($sformatf("line_length reads 0x%02h, written 0x%02h", csr_prdata[7:0], value));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // test sequence holds off until every word is taken and every char has come
   task automatic drain();
      while (words_taken != words_queued) @(posedge clock);
      while (char_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      logic [7:0]  lengths[8];
      int unsigned budgets[8];
      lengths = '{8'd0, 8'd4, 8'd1, 8'd252, 8'd255, 8'd5, 8'd64, 8'd0};
      budgets = '{15, 15, 15, 200, 15, 15, 15, 20};
      lengths[7] = 8'($urandom_range(0, 255));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_line_length(8'd4);
      push_word(8'hff, 1'b1, 1'b1);                 // empty message
      push_word(8'h00, 1'b1, 1'b0);                 // one byte, two pads
      push_word(8'hff, 1'b0, 1'b0);
      push_word(8'hff, 1'b1, 1'b0);                 // two bytes, one pad
      push_word(8'h00, 1'b0, 1'b0);
      push_word(8'h10, 1'b0, 1'b0);
      push_word(8'h83, 1'b1, 1'b0);                 // full line but last: no wrap
      push_word(8'hff, 1'b0, 1'b0);
      push_word(8'hef, 1'b0, 1'b0);
      push_word(8'hbe, 1'b0, 1'b0);
      push_word(8'h00, 1'b0, 1'b0);
      push_word(8'h00, 1'b0, 1'b0);
      push_word(8'h00, 1'b0, 1'b0);
      push_word(8'h5a, 1'b1, 1'b0);
      push_word(8'h11, 1'b0, 1'b0);
      push_word(8'h22, 1'b0, 1'b0);
      push_word(8'h00, 1'b0, 1'b1);                 // drops two pending bytes
      push_word(8'hfe, 1'b0, 1'b0);
      push_word(8'hdc, 1'b0, 1'b0);
      push_word(8'hba, 1'b0, 1'b0);
      push_word(8'h98, 1'b0, 1'b0);                 // message stays open
      drain();

      for (int i = 0; i < 8; i++) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         set_line_length(lengths[i]);
         queue_messages(budgets[i], (lengths[i] == 8'd252) ? 195 : 0);
         drain();
      end

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
